FILE: sv/mra_pkg.sv
// mra_pkg: shared constants, codes, types and helpers for the modem rate adaptation block
// no dependencies; imported by mra_cfg, mra_step, modem_rate_adaptation and tb_top
package mra_pkg;

  // level counts and event constants
  localparam int SINGLE_LEVELS   = 6;
  localparam int OFDM_LEVELS     = 6;
  localparam int UPSHIFT_HOLD    = 4;
  localparam int FAIL_LIMIT      = 2;
  localparam int COOLDOWN_LENGTH = 30;
  localparam int EASY_ITERATIONS = 3;

  localparam int HARD_ITERATIONS = 30;
  localparam int MARGIN_STEP     = 20;
  localparam int MARGIN_FULL     = 32;
  localparam int MARGIN_HALF     = 16;
  localparam int BOOST_GAIN      = 77;
  localparam int DRAIN_PERIOD    = 4;

  localparam int THR_W     = 12;
  localparam int THR_SLOTS = 5;
  localparam int SINGLE_THR_N = (SINGLE_LEVELS - 1 > THR_SLOTS) ? THR_SLOTS : SINGLE_LEVELS - 1;
  localparam int OFDM_THR_N   = (OFDM_LEVELS - 1 > THR_SLOTS) ? THR_SLOTS : OFDM_LEVELS - 1;

  localparam logic [2:0] SINGLE_MAX = 3'(SINGLE_LEVELS - 1);
  localparam logic [2:0] OFDM_MAX   = 3'(OFDM_LEVELS - 1);

  localparam logic [8:0] ALPHA_RESET = 9'd64;
  localparam logic [7:0] HOLD_RESET  = 8'd4;

  typedef enum logic [2:0] {
    CMD_SINGLE_SNR  = 3'd0,
    CMD_OFDM_SNR    = 3'd1,
    CMD_LDPC        = 3'd2,
    CMD_FAILURE     = 3'd3,
    CMD_FORCE_SNGL  = 3'd4,
    CMD_FORCE_OFDM  = 3'd5,
    CMD_LOCK_SNGL   = 3'd6,
    CMD_NONE        = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    REG_SINGLE_THR   = 3'd0,
    REG_OFDM_THR     = 3'd1,
    REG_SINGLE_CEIL  = 3'd2,
    REG_OFDM_CEIL    = 3'd3,
    REG_ALPHA        = 3'd4,
    REG_HOLD_COUNT   = 3'd5,
    REG_FAST_RAMP    = 3'd6,
    REG_STICKY_CLIMB = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [59:0] single_thr;
    logic [59:0] ofdm_thr;
    logic [2:0]  single_ceil;
    logic [2:0]  ofdm_ceil;
    logic [8:0]  alpha;
    logic [7:0]  hold_count;
    logic        fast_ramp;
    logic        sticky_climb;
  } mra_cfg_t;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [11:0] snr_sample;
    logic [7:0]         iteration_count;
    logic [7:0]         iteration_limit;
    logic [2:0]         level_request;
  } mra_item_t;

  typedef struct packed {
    logic [2:0]         single_level;
    logic [2:0]         ofdm_level;
    logic               locked;
    logic               avg_valid;
    logic signed [19:0] snr_average;
    logic [7:0]         hold_cnt;
    logic [3:0]         fail_cnt;
    logic [2:0]         drain_cnt;
    logic [5:0]         margin_boost;
    logic               hard_gate;
    logic [7:0]         cooldown_cnt;
    logic               easy_decode;
    logic               decode_ok;
  } mra_state_t;

  localparam mra_state_t STATE_RESET = '0;

  // ceiling above the top level acts as the top level
  function automatic logic [2:0] eff_ceil(logic [2:0] c, logic [2:0] top);
    return (c > top) ? top : c;
  endfunction

endpackage

FILE: sv/mra_cfg.sv
// mra_cfg: configuration register file, written through a plain write port
// depends on mra_pkg
module mra_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [59:0]       cfg_data,
  output mra_pkg::mra_cfg_t cfg
);
  import mra_pkg::*;

  mra_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.single_thr   <= '0;
      cfg_r.ofdm_thr     <= '0;
      cfg_r.single_ceil  <= SINGLE_MAX;
      cfg_r.ofdm_ceil    <= OFDM_MAX;
      cfg_r.alpha        <= ALPHA_RESET;
      cfg_r.hold_count   <= HOLD_RESET;
      cfg_r.fast_ramp    <= 1'b0;
      cfg_r.sticky_climb <= 1'b0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_SINGLE_THR:   cfg_r.single_thr   <= cfg_data;
        REG_OFDM_THR:     cfg_r.ofdm_thr     <= cfg_data;
        REG_SINGLE_CEIL:  cfg_r.single_ceil  <= cfg_data[2:0];
        REG_OFDM_CEIL:    cfg_r.ofdm_ceil    <= cfg_data[2:0];
        REG_ALPHA:        cfg_r.alpha        <= cfg_data[8:0];
        REG_HOLD_COUNT:   cfg_r.hold_count   <= cfg_data[7:0];
        REG_FAST_RAMP:    cfg_r.fast_ramp    <= cfg_data[0];
        REG_STICKY_CLIMB: cfg_r.sticky_climb <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: sv/mra_step.sv
// mra_step: next-state logic for one event (smoothing, level map, counters)
// depends on mra_pkg
module mra_step (
  input  mra_pkg::mra_state_t st,
  input  mra_pkg::mra_cfg_t   cfg,
  input  mra_pkg::mra_item_t  item,
  output mra_pkg::mra_state_t ns
);
  import mra_pkg::*;

  // count thresholds at or below the effective snr
  function automatic logic [2:0] level_count(logic [59:0] thr, logic signed [20:0] eff, int n);
    logic [2:0]         cnt;
    logic [11:0]        t;
    logic signed [20:0] t_s;
    cnt = 3'd0;
    for (int i = 0; i < THR_SLOTS; i++) begin
      t   = thr[THR_W*i +: THR_W];
      t_s = signed'({t[11], t, 8'd0});
      if (i < n && t_s <= eff) cnt = cnt + 3'd1;
    end
    return cnt;
  endfunction

  function automatic logic [7:0] drain(logic [7:0] cd, logic [2:0] lvl);
    logic [7:0] d;
    d = (lvl <= 3'd1) ? 8'd2 : 8'd1;
    return (cd > d) ? cd - d : 8'd0;
  endfunction

  cmd_t               cmd;
  logic [8:0]         a_eff;
  logic signed [9:0]  a_s;
  logic signed [9:0]  w_s;
  logic signed [21:0] p_new;
  logic signed [29:0] p_old;
  logic signed [21:0] old_part;
  logic signed [19:0] avg_new;
  logic signed [20:0] eff;
  logic [2:0]         s_ceil, o_ceil;
  logic [2:0]         s_cnt, o_cnt;
  logic [2:0]         s_tgt, o_tgt;
  logic [7:0]         hold_bump;
  logic [3:0]         fail_inc;
  logic [2:0]         drain_inc;
  logic [12:0]        k;
  logic [9:0]         lim3;
  logic [5:0]         b_tgt;
  logic [5:0]         b_diff;
  logic [11:0]        b_prod;
  logic               sngl_down;
  logic [2:0]         f_sngl, f_ofdm;

  assign cmd = cmd_t'(item.command);

  // running average: new = alpha*sample + floor((256-alpha)*avg/256)
  assign a_eff    = (cfg.alpha > 9'd256) ? 9'd256 : cfg.alpha;
  assign a_s      = signed'({1'b0, a_eff});
  assign w_s      = 10'sd256 - a_s;
  assign p_new    = a_s * item.snr_sample;
  assign p_old    = w_s * st.snr_average;
  assign old_part = 22'(p_old >>> 8);
  assign avg_new  = st.avg_valid ? 20'(p_new + old_part) : {item.snr_sample, 8'd0};

  assign eff   = 21'(avg_new) + signed'(21'({st.margin_boost, 8'd0}));
  assign s_cnt = level_count(cfg.single_thr, eff, SINGLE_THR_N);
  assign o_cnt = level_count(cfg.ofdm_thr, eff, OFDM_THR_N);

  assign s_ceil = eff_ceil(cfg.single_ceil, SINGLE_MAX);
  assign o_ceil = eff_ceil(cfg.ofdm_ceil, OFDM_MAX);
  assign s_tgt  = (s_cnt > s_ceil) ? s_ceil : s_cnt;

  always_comb begin
    o_tgt = o_cnt;
    // easy decodes pull the target one above the current level
    if (st.easy_decode && st.ofdm_level < o_ceil &&
        {1'b0, o_cnt} < {1'b0, st.ofdm_level} + 4'd1) begin
      o_tgt = st.ofdm_level + 3'd1;
    end
    if (o_tgt > o_ceil) o_tgt = o_ceil;
  end

  assign hold_bump = (st.hold_cnt != 8'hFF) ? st.hold_cnt + 8'd1 : st.hold_cnt;
  assign fail_inc  = (st.fail_cnt != 4'hF) ? st.fail_cnt + 4'd1 : st.fail_cnt;
  assign drain_inc = st.drain_cnt + 3'd1;

  // decode margin target from iteration use
  assign k    = 13'(MARGIN_STEP) * (13'(item.iteration_count) - 13'd1);
  assign lim3 = 10'(item.iteration_limit) * 10'd3;
  always_comb begin
    if (k < 13'(item.iteration_limit))  b_tgt = 6'(MARGIN_FULL);
    else if (k < 13'(lim3))             b_tgt = 6'(MARGIN_HALF);
    else                                b_tgt = 6'd0;
  end
  assign b_diff = b_tgt - st.margin_boost;
  assign b_prod = 12'(BOOST_GAIN) * 12'(b_diff);

  assign sngl_down = !st.locked && st.single_level != 3'd0;
  assign f_sngl    = (item.level_request > s_ceil) ? s_ceil : item.level_request;
  assign f_ofdm    = (item.level_request > o_ceil) ? o_ceil : item.level_request;

  always_comb begin
    ns = st;
    case (cmd)
      CMD_SINGLE_SNR: begin
        if (!st.locked) begin
          ns.avg_valid   = 1'b1;
          ns.snr_average = avg_new;
          if (st.cooldown_cnt != 8'd0) ns.cooldown_cnt = drain(st.cooldown_cnt, st.single_level);
          if (st.fail_cnt != 4'd0) ns.fail_cnt = st.fail_cnt - 4'd1;
          if (s_tgt > st.single_level && ns.cooldown_cnt == 8'd0 && !st.hard_gate) begin
            ns.hold_cnt = hold_bump;
            if (hold_bump >= 8'(UPSHIFT_HOLD)) begin
              ns.single_level = st.single_level + 3'd1;
              ns.hold_cnt     = 8'd0;
            end
          end else if (s_tgt < st.single_level) begin
            ns.single_level = s_tgt;
            ns.hold_cnt     = 8'd0;
            ns.fail_cnt     = 4'd0;
          end
        end
      end
      CMD_OFDM_SNR: begin
        ns.avg_valid   = 1'b1;
        ns.snr_average = avg_new;
        if (st.cooldown_cnt != 8'd0) ns.cooldown_cnt = drain(st.cooldown_cnt, st.ofdm_level);
        if (st.fail_cnt != 4'd0) begin
          ns.drain_cnt = drain_inc;
          if (drain_inc >= 3'(DRAIN_PERIOD)) begin
            ns.fail_cnt  = st.fail_cnt - 4'd1;
            ns.drain_cnt = 3'd0;
          end
        end else begin
          ns.drain_cnt = 3'd0;
        end
        if (o_tgt > st.ofdm_level && ns.cooldown_cnt == 8'd0 && !st.hard_gate) begin
          ns.hold_cnt = hold_bump;
          if (hold_bump >= cfg.hold_count) begin
            ns.ofdm_level = cfg.fast_ramp ? o_tgt : st.ofdm_level + 3'd1;
            ns.hold_cnt   = 8'd0;
          end
        end else if (o_tgt < st.ofdm_level && !(cfg.sticky_climb && st.decode_ok)) begin
          ns.ofdm_level = o_tgt;
          ns.hold_cnt   = 8'd0;
          ns.fail_cnt   = 4'd0;
        end
      end
      CMD_LDPC: begin
        if (item.iteration_count != 8'd0 && item.iteration_limit != 8'd0) begin
          ns.hard_gate   = item.iteration_count > 8'(HARD_ITERATIONS);
          ns.easy_decode = item.iteration_count <= 8'(EASY_ITERATIONS);
          ns.decode_ok   = 1'b1;
          if (b_tgt > st.margin_boost) ns.margin_boost = st.margin_boost + 6'(b_prod[11:8]);
          else                         ns.margin_boost = b_tgt;
        end
      end
      CMD_FAILURE: begin
        ns.fail_cnt     = fail_inc;
        ns.hold_cnt     = 8'd0;
        ns.margin_boost = 6'd0;
        ns.easy_decode  = 1'b0;
        ns.decode_ok    = 1'b0;
        if (fail_inc >= 4'(FAIL_LIMIT)) begin
          if (sngl_down) ns.single_level = st.single_level - 3'd1;
          if (st.ofdm_level != 3'd0) ns.ofdm_level = st.ofdm_level - 3'd1;
          ns.fail_cnt = 4'd0;
          if (sngl_down || st.ofdm_level != 3'd0) ns.cooldown_cnt = 8'(COOLDOWN_LENGTH);
        end
      end
      CMD_FORCE_SNGL, CMD_LOCK_SNGL, CMD_FORCE_OFDM: begin
        ns.hold_cnt     = 8'd0;
        ns.fail_cnt     = 4'd0;
        ns.drain_cnt    = 3'd0;
        ns.margin_boost = 6'd0;
        ns.hard_gate    = 1'b0;
        ns.easy_decode  = 1'b0;
        ns.decode_ok    = 1'b0;
        ns.cooldown_cnt = 8'd0;
        if (cmd == CMD_FORCE_OFDM) begin
          ns.ofdm_level = f_ofdm;
          if (f_ofdm == 3'd0) begin
            ns.avg_valid   = 1'b0;
            ns.snr_average = '0;
          end
        end else begin
          ns.single_level = f_sngl;
          if (cmd == CMD_LOCK_SNGL) ns.locked = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: sv/modem_rate_adaptation.sv
// modem_rate_adaptation: top level of the adaptive speed-level selector
// depends on mra_pkg, mra_cfg and mra_step
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-----------------------------------------
//  in_      | input     | in_valid / in_ready  | command, snr_sample, iteration counts, req
//  out_     | output    | out_valid / out_ready| single_level, ofdm_level, cooldown_active
//  cfg_     | input     | cfg_we (no wait)     | cfg_index, cfg_data
//
// one event per cycle sustained while out_ready stays high; out_valid rises once the event
// has gone through the input register, then the event logic into the result register
// the state update for an event happens in the single step between those two
// registers, so each event sees the state left by the one before it
// a stalled out_ side holds the result register; the input register still
// takes one more event, then in_ready drops until the result moves on
// synchronous active-low reset clears levels, counters and the smoothed snr
module modem_rate_adaptation (
  input  logic        clk,
  input  logic        rst_n,
  // event channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_command,
  input  logic signed [11:0] in_snr_sample,
  input  logic [7:0]  in_iteration_count,
  input  logic [7:0]  in_iteration_limit,
  input  logic [2:0]  in_level_request,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_single_level,
  output logic [2:0]  out_ofdm_level,
  output logic        out_cooldown_active,
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [59:0] cfg_data
);
  import mra_pkg::*;

  mra_cfg_t   cfg;
  mra_item_t  item_r;
  mra_state_t state_r, state_nxt, step_state;
  logic       in_valid_r;
  logic       out_valid_r;
  logic [2:0] out_single_r, out_ofdm_r;
  logic       out_cool_r;
  logic       advance;
  logic [2:0] s_ceil_wr, o_ceil_wr;

  mra_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mra_step u_step (
    .st   (state_r),
    .cfg  (cfg),
    .item (item_r),
    .ns   (step_state)
  );

  // the held event moves into the result register when that is empty or draining
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  // a ceiling write pulls the current level down to the new ceiling, unless an event advances in that cycle
  assign s_ceil_wr = eff_ceil(cfg_data[2:0], SINGLE_MAX);
  assign o_ceil_wr = eff_ceil(cfg_data[2:0], OFDM_MAX);

  always_comb begin
    state_nxt = state_r;
    if (advance) begin
      state_nxt = step_state;
    end else if (cfg_we) begin
      if (reg_idx_t'(cfg_index) == REG_SINGLE_CEIL && state_r.single_level > s_ceil_wr)
        state_nxt.single_level = s_ceil_wr;
      if (reg_idx_t'(cfg_index) == REG_OFDM_CEIL && state_r.ofdm_level > o_ceil_wr)
        state_nxt.ofdm_level = o_ceil_wr;
    end
  end

  // control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= STATE_RESET;
    end else begin
      state_r <= state_nxt;
      if (in_ready) in_valid_r <= in_valid;
      if (advance) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.command         <= in_command;
      item_r.snr_sample      <= in_snr_sample;
      item_r.iteration_count <= in_iteration_count;
      item_r.iteration_limit <= in_iteration_limit;
      item_r.level_request   <= in_level_request;
    end
    if (advance) begin
      out_single_r <= step_state.single_level;
      out_ofdm_r   <= step_state.ofdm_level;
      out_cool_r   <= step_state.cooldown_cnt != 8'd0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_single_level    = out_single_r;
  assign out_ofdm_level      = out_ofdm_r;
  assign out_cooldown_active = out_cool_r;

  // fail counter is cleared whenever it reaches the limit
  a_fail_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.fail_cnt < 4'(FAIL_LIMIT))
    else $error("fail counter reached its limit without a downshift");

  // drain counter restarts at the drain period
  a_drain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.drain_cnt < 3'(DRAIN_PERIOD))
    else $error("drain counter past its period");

  a_boost_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.margin_boost <= 6'(MARGIN_FULL))
    else $error("margin boost above full margin");

  // only reset releases the single-carrier lock
  a_lock_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.locked |=> state_r.locked)
    else $error("lock released without reset");

  // the smoothed snr moves only with an event transfer into the result stage
  a_avg_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(state_r.snr_average))
    else $error("snr average changed without an event");

endmodule

FILE: verif/tb_top.sv
// tb_top: self-checking bench for the modem rate adaptation block (modem_rate_adaptation)
// depends on mra_pkg for the command and register codes, the item type and the level and event constants
// directed rows, then random event phases under changing register settings, with the lock rows before the last phase
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mra_pkg::*;

  // run limit, far above the slowest legal run
  localparam longint LIMIT_NS = 2_000_000;
  localparam int N_EARLY = 19;     // directed rows before the random phases
  localparam int N_LATE = 5;       // lock rows, run near the end since a lock never clears
  localparam int N_PHASES = 8;     // register settings for the random part
  localparam int PHASE_ITEMS = 85;
  localparam int HOLD_OFF_AT = 250;  // result count at which the sink stops for a long stretch
  localparam int HOLD_OFF_LEN = 150;
  localparam int PRINT_CAP = 100;

  // one result: both levels and the cooldown flag
  typedef struct packed {
    logic [2:0] single;
    logic [2:0] ofdm;
    logic       cool;
  } levels_t;

  // one directed row; want is used only where typed is set
  typedef struct packed {
    cmd_t               cmd;
    logic signed [11:0] snr;
    logic [7:0]         cnt;
    logic [7:0]         lim;
    logic [2:0]         req;
    logic               typed;
    levels_t            want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_ready;
  logic [2:0] in_command;
  logic signed [11:0] in_snr_sample;
  logic [7:0] in_iteration_count, in_iteration_limit;
  logic [2:0] in_level_request;
  logic out_valid, out_ready;
  logic [2:0] out_single_level, out_ofdm_level;
  logic out_cooldown_active;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [59:0] cfg_data;

  modem_rate_adaptation uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_command          (in_command),
    .in_snr_sample       (in_snr_sample),
    .in_iteration_count  (in_iteration_count),
    .in_iteration_limit  (in_iteration_limit),
    .in_level_request    (in_level_request),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_single_level    (out_single_level),
    .out_ofdm_level      (out_ofdm_level),
    .out_cooldown_active (out_cooldown_active),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // directed rows, typed results only where they follow straight from reset state
  row_t plan [N_EARLY + N_LATE] = '{
    // unused command with every field at its top: nothing moves
    '{CMD_NONE, 12'sh7ff, 8'hff, 8'hff, 3'd7, 1'b1, '{3'd0, 3'd0, 1'b0}},
    // zero iteration count, then zero limit: ldpc event ignored
    '{CMD_LDPC, 12'sh000, 8'h00, 8'hff, 3'd0, 1'b1, '{3'd0, 3'd0, 1'b0}},
    '{CMD_LDPC, 12'sh000, 8'hff, 8'h00, 3'd0, 1'b1, '{3'd0, 3'd0, 1'b0}},
    // requests above the ceiling clamp to level 5
    '{CMD_FORCE_SNGL, 12'sh555, 8'h0f, 8'hf0, 3'd7, 1'b1, '{3'd5, 3'd0, 1'b0}},
    '{CMD_FORCE_OFDM, 12'shaaa, 8'hf0, 8'h0f, 3'd7, 1'b1, '{3'd5, 3'd5, 1'b0}},
    // first failure only counts, second drops both levels and starts the cooldown
    '{CMD_FAILURE, 12'sh000, 8'h00, 8'h00, 3'd0, 1'b1, '{3'd5, 3'd5, 1'b0}},
    '{CMD_FAILURE, 12'sh7ff, 8'hff, 8'hff, 3'd7, 1'b1, '{3'd4, 3'd4, 1'b1}},
    // snr extremes, ldpc boosts and the hard gate
    '{CMD_OFDM_SNR, 12'sh800, 8'h00, 8'h00, 3'd0, 1'b0, '{3'd0, 3'd0, 1'b0}},
    '{CMD_SINGLE_SNR, 12'sh7ff, 8'h00, 8'h00, 3'd0, 1'b0, '{3'd0, 3'd0, 1'b0}},
    '{CMD_LDPC, 12'sh800, 8'h01, 8'hff, 3'd5, 1'b0, '{3'd0, 3'd0, 1'b0}},
    '{CMD_OFDM_SNR, 12'sh000, 8'h00, 8'h00, 3'd0, 1'b0, '{3'd0, 3'd0, 1'b0}},
    '{CMD_LDPC, 12'sh123, 8'hff, 8'hff, 3'd2, 1'b0, '{3'd0, 3'd0, 1'b0}},
    '{CMD_SINGLE_SNR, 12'sh000, 8'h00, 8'h00, 3'd0, 1'b0, '{3'd0, 3'd0, 1'b0}},
    '{CMD_LDPC, 12'sh000, 8'h02, 8'h0a, 3'd0, 1'b0, '{3'd0, 3'd0, 1'b0}},
    // forcing ofdm to level 0 restarts the smoothed snr
    '{CMD_FORCE_OFDM, 12'sh7ff, 8'hff, 8'hff, 3'd0, 1'b0, '{3'd0, 3'd0, 1'b0}},
    '{CMD_OFDM_SNR, 12'sh7ff, 8'h00, 8'h00, 3'd0, 1'b0, '{3'd0, 3'd0, 1'b0}},
    '{CMD_FORCE_SNGL, 12'sh800, 8'h00, 8'h00, 3'd0, 1'b0, '{3'd0, 3'd0, 1'b0}},
    '{CMD_NONE, 12'sh800, 8'h00, 8'h00, 3'd0, 1'b0, '{3'd0, 3'd0, 1'b0}},
    '{CMD_SINGLE_SNR, 12'sh7ff, 8'h00, 8'h00, 3'd0, 1'b0, '{3'd0, 3'd0, 1'b0}},
    // lock rows: locked single snr ignored, failures leave single alone
    '{CMD_LOCK_SNGL, 12'sh000, 8'h00, 8'h00, 3'd7, 1'b0, '{3'd0, 3'd0, 1'b0}},
    '{CMD_SINGLE_SNR, 12'sh800, 8'h00, 8'h00, 3'd0, 1'b0, '{3'd0, 3'd0, 1'b0}},
    '{CMD_FAILURE, 12'sh000, 8'h00, 8'h00, 3'd0, 1'b0, '{3'd0, 3'd0, 1'b0}},
    '{CMD_FAILURE, 12'sh000, 8'h00, 8'h00, 3'd0, 1'b0, '{3'd0, 3'd0, 1'b0}},
    '{CMD_LOCK_SNGL, 12'sh7ff, 8'hff, 8'hff, 3'd0, 1'b0, '{3'd0, 3'd0, 1'b0}}
  };

  // ---------------------------------------------------------------------------
  // level selector model: register copy and state at the block's widths
  // ---------------------------------------------------------------------------
  logic [59:0] c_sthr, c_othr;
  logic [2:0]  c_sceil, c_oceil;
  logic [8:0]  c_alpha;
  logic [7:0]  c_hold;
  logic        c_fast, c_sticky;

  logic [2:0]         sc_lvl, of_lvl;
  logic               locked, avg_ok;
  logic signed [19:0] snr_avg;
  logic [7:0]         hold_n;
  logic [3:0]         fail_n;
  logic [2:0]         drain_n;
  logic [5:0]         boost;
  logic               hard, easy, dec_ok;
  logic [7:0]         cool;

  levels_t level_q [$];   // results still owed by the block, oldest first

  int n_errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_settings = 0;
  bit send_quiet = 1'b0;
  int chan;               // wandering channel snr for the random reports

  function automatic void selector_reset();
    c_sthr = '0;
    c_othr = '0;
    c_sceil = 3'(SINGLE_LEVELS - 1);
    c_oceil = 3'(OFDM_LEVELS - 1);
    c_alpha = 9'd64;
    c_hold = 8'd4;
    c_fast = 1'b0;
    c_sticky = 1'b0;
    sc_lvl = '0;
    of_lvl = '0;
    locked = 1'b0;
    avg_ok = 1'b0;
    snr_avg = '0;
    clear_drivers();
  endfunction

  function automatic void clear_drivers();
    hold_n = '0;
    fail_n = '0;
    drain_n = '0;
    boost = '0;
    hard = 1'b0;
    easy = 1'b0;
    dec_ok = 1'b0;
    cool = '0;
  endfunction

  // ceiling codes above the top level behave as the top level
  function automatic logic [2:0] top_limited(logic [2:0] c, int levels);
    return (int'(c) > levels - 1) ? 3'(levels - 1) : c;
  endfunction

  // count ladder rungs at or below the effective snr (average plus boost)
  function automatic logic [2:0] ladder_level(logic [59:0] thr, int levels);
    int eff, n, cnt;
    logic signed [11:0] rung;
    eff = int'(snr_avg) + int'(boost) * 256;
    n = (levels - 1 > 5) ? 5 : levels - 1;
    cnt = 0;
    for (int i = 0; i < n; i++) begin
      rung = thr[12*i +: 12];
      if (int'(rung) * 256 <= eff) cnt++;
    end
    return 3'(cnt);
  endfunction

  function automatic void smooth_snr(logic signed [11:0] s);
    longint a, t;
    if (!avg_ok) begin
      snr_avg = 20'(int'(s) * 256);
      avg_ok = 1'b1;
    end else begin
      a = (c_alpha > 9'd256) ? 256 : longint'(c_alpha);
      t = a * longint'(s) * 256 + (256 - a) * longint'(snr_avg);
      snr_avg = 20'(t >>> 8);  // floor division by 256
    end
  endfunction

  // cooldown falls twice as fast at the bottom two levels
  function automatic void drain_cool(logic [2:0] lvl);
    logic [7:0] d;
    d = (lvl <= 3'd1) ? 8'd2 : 8'd1;
    cool = (cool > d) ? cool - d : 8'd0;
  endfunction

  function automatic void single_report(logic signed [11:0] s);
    logic [2:0] cap, tgt;
    if (locked) return;
    smooth_snr(s);
    cap = top_limited(c_sceil, SINGLE_LEVELS);
    tgt = ladder_level(c_sthr, SINGLE_LEVELS);
    if (tgt > cap) tgt = cap;
    if (cool != 0) drain_cool(sc_lvl);
    if (fail_n != 0) fail_n--;
    if (tgt > sc_lvl && cool == 0 && !hard) begin
      if (hold_n < 8'd255) hold_n++;
      if (int'(hold_n) >= UPSHIFT_HOLD) begin
        sc_lvl++;
        hold_n = '0;
      end
    end else if (tgt < sc_lvl) begin
      sc_lvl = tgt;
      hold_n = '0;
      fail_n = '0;
    end
  endfunction

  function automatic void ofdm_report(logic signed [11:0] s);
    logic [2:0] cap, tgt;
    cap = top_limited(c_oceil, OFDM_LEVELS);
    smooth_snr(s);
    tgt = ladder_level(c_othr, OFDM_LEVELS);
    // easy decodes nudge the target one level up
    if (easy && of_lvl < cap && tgt < of_lvl + 3'd1) tgt = of_lvl + 3'd1;
    if (tgt > cap) tgt = cap;
    if (cool != 0) drain_cool(of_lvl);
    if (fail_n != 0) begin
      drain_n++;
      if (int'(drain_n) >= DRAIN_PERIOD) begin
        fail_n--;
        drain_n = '0;
      end
    end else begin
      drain_n = '0;
    end
    if (tgt > of_lvl && cool == 0 && !hard) begin
      if (hold_n < 8'd255) hold_n++;
      if (hold_n >= c_hold) begin
        of_lvl = c_fast ? tgt : of_lvl + 3'd1;
        hold_n = '0;
      end
    end else if (tgt < of_lvl && !(c_sticky && dec_ok)) begin
      of_lvl = tgt;
      hold_n = '0;
      fail_n = '0;
    end
  endfunction

  function automatic void ldpc_report(logic [7:0] cnt, logic [7:0] lim);
    int k, tgt, b;
    if (cnt == 0 || lim == 0) return;
    hard = int'(cnt) > HARD_ITERATIONS;
    easy = int'(cnt) <= EASY_ITERATIONS;
    dec_ok = 1'b1;
    k = MARGIN_STEP * (int'(cnt) - 1);
    if (k < int'(lim)) tgt = MARGIN_FULL;
    else if (k < 3 * int'(lim)) tgt = MARGIN_HALF;
    else tgt = 0;
    b = int'(boost);
    if (tgt > b) b = b + ((BOOST_GAIN * (tgt - b)) >> 8);
    else b = tgt;
    boost = 6'(b);
  endfunction

  function automatic void decode_failure();
    bit drop_single, any_drop;
    if (fail_n < 4'd15) fail_n++;
    hold_n = '0;
    boost = '0;
    easy = 1'b0;
    dec_ok = 1'b0;
    if (int'(fail_n) >= FAIL_LIMIT) begin
      drop_single = !locked && sc_lvl > 0;
      any_drop = drop_single || of_lvl > 0;
      if (drop_single) sc_lvl--;
      if (of_lvl > 0) of_lvl--;
      hold_n = '0;
      fail_n = '0;
      if (any_drop) cool = 8'(COOLDOWN_LENGTH);
    end
  endfunction

  // advance the model by one event and give the levels after it
  function automatic levels_t step_selector(mra_item_t it);
    levels_t r;
    logic [2:0] cap;
    case (cmd_t'(it.command))
      CMD_SINGLE_SNR: single_report(it.snr_sample);
      CMD_OFDM_SNR:   ofdm_report(it.snr_sample);
      CMD_LDPC:       ldpc_report(it.iteration_count, it.iteration_limit);
      CMD_FAILURE:    decode_failure();
      CMD_FORCE_SNGL, CMD_LOCK_SNGL: begin
        cap = top_limited(c_sceil, SINGLE_LEVELS);
        sc_lvl = (it.level_request > cap) ? cap : it.level_request;
        clear_drivers();
        if (cmd_t'(it.command) == CMD_LOCK_SNGL) locked = 1'b1;
      end
      CMD_FORCE_OFDM: begin
        cap = top_limited(c_oceil, OFDM_LEVELS);
        of_lvl = (it.level_request > cap) ? cap : it.level_request;
        clear_drivers();
        if (of_lvl == 0) begin
          avg_ok = 1'b0;
          snr_avg = '0;
        end
      end
      default: ;
    endcase
    r.single = sc_lvl;
    r.ofdm = of_lvl;
    r.cool = (cool != 0);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------
  task automatic flag_error(string what, int got, int want);
    if (n_errors < PRINT_CAP)
      $display("mismatch %0d at %0t: %s got %0d want %0d", n_errors + 1, $realtime, what,
               got, want);
    n_errors++;
  endtask

  // each result transfer is matched against the oldest expectation
  always @(posedge clk) begin
    levels_t want;
    if (rst_n && out_valid && out_ready) begin
      if (level_q.size() == 0) begin
        flag_error("unexpected result, single_level", out_single_level, -1);
      end else begin
        want = level_q.pop_front();
        if (out_single_level !== want.single)
          flag_error("single_level", out_single_level, want.single);
        if (out_ofdm_level !== want.ofdm)
          flag_error("ofdm_level", out_ofdm_level, want.ofdm);
        if (out_cooldown_active !== want.cool)
          flag_error("cooldown_active", out_cooldown_active, want.cool);
        n_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result sink: random stalls, quiet stretches, and one long hold-off
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    int taken;
    bit quiet;
    taken = 0;
    quiet = 1'b0;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 3);
      // long hold-off: the sender keeps offering, so the block fills and stalls in_
      if (taken == HOLD_OFF_AT) stall = HOLD_OFF_LEN;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
      if (taken % 40 == 0) quiet = ($urandom_range(0, 2) == 0);
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // offer one event from a falling edge and hold it until the transfer
  task automatic send_event(mra_item_t it, bit typed, levels_t want);
    int gap;
    levels_t p;
    gap = send_quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= it.command;
    in_snr_sample <= it.snr_sample;
    in_iteration_count <= it.iteration_count;
    in_iteration_limit <= it.iteration_limit;
    in_level_request <= it.level_request;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p = step_selector(it);
    level_q = {level_q, (typed ? want : p)};
    n_sent++;
    if (n_sent % 40 == 0) send_quiet = ($urandom_range(0, 2) == 0);
    @(negedge clk);
  endtask

  task automatic send_row(row_t r);
    mra_item_t it;
    it.command = r.cmd;
    it.snr_sample = r.snr;
    it.iteration_count = r.cnt;
    it.iteration_limit = r.lim;
    it.level_request = r.req;
    send_event(it, r.typed, r.want);
  endtask

  // drop in_valid and wait until every owed result has left the block
  task automatic settle();
    in_valid <= 1'b0;
    while (level_q.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // register write from a falling edge; the model takes it at the same time
  task automatic put_reg(reg_idx_t idx, logic [59:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_SINGLE_THR: c_sthr = val;
      REG_OFDM_THR:   c_othr = val;
      REG_SINGLE_CEIL: begin
        c_sceil = val[2:0];
        if (sc_lvl > top_limited(c_sceil, SINGLE_LEVELS))
          sc_lvl = top_limited(c_sceil, SINGLE_LEVELS);
      end
      REG_OFDM_CEIL: begin
        c_oceil = val[2:0];
        if (of_lvl > top_limited(c_oceil, OFDM_LEVELS))
          of_lvl = top_limited(c_oceil, OFDM_LEVELS);
      end
      REG_ALPHA:        c_alpha = val[8:0];
      REG_HOLD_COUNT:   c_hold = val[7:0];
      REG_FAST_RAMP:    c_fast = val[0];
      REG_STICKY_CLIMB: c_sticky = val[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // five ascending 12-bit thresholds starting near lo
  function automatic logic [59:0] ladder(int lo, int span);
    logic [59:0] v;
    int t;
    v = '0;
    t = lo;
    for (int i = 0; i < 5; i++) begin
      t = t + int'($urandom_range(0, span));
      if (t > 2047) t = 2047;
      v[12*i +: 12] = 12'(t);
    end
    return v;
  endfunction

  // register settings per phase; phase 0 keeps the reset values with a low ladder, phases 1 to 4 pin the extremes
  task automatic program_setting(int ph);
    logic [59:0] st, ot;
    logic [2:0] sc_c, oc_c;
    logic [8:0] al;
    logic [7:0] hc;
    logic fr, sk;
    case (ph)
      0: begin
        st = ladder(-400, 200); ot = ladder(-400, 200);
        sc_c = 3'd5; oc_c = 3'd5; al = 9'd64; hc = 8'd4; fr = 1'b0; sk = 1'b0;
      end
      1: begin
        st = ladder(-700, 300); ot = ladder(-700, 300);
        sc_c = 3'd7; oc_c = 3'd6; al = 9'd256; hc = 8'd0; fr = 1'b1; sk = 1'b1;
      end
      2: begin
        st = 60'({$urandom, $urandom}); ot = 60'({$urandom, $urandom});
        sc_c = 3'd0; oc_c = 3'd0; al = 9'd0; hc = 8'd255; fr = 1'b0; sk = 1'b1;
      end
      3: begin
        // every rung at the bottom of the snr range
        st = {5{12'h800}}; ot = {5{12'h800}};
        sc_c = 3'd3; oc_c = 3'd2; al = 9'd511; hc = 8'd1; fr = 1'b1; sk = 1'b0;
      end
      4: begin
        // every rung at the top of the snr range
        st = {5{12'h7ff}}; ot = {5{12'h7ff}};
        sc_c = 3'd5; oc_c = 3'd5; al = 9'd1; hc = 8'd2; fr = 1'b0; sk = 1'b0;
      end
      default: begin
        st = ($urandom_range(0, 3) != 0) ? ladder(int'($urandom_range(0, 1200)) - 800, 250)
                                          : 60'({$urandom, $urandom});
        ot = ($urandom_range(0, 3) != 0) ? ladder(int'($urandom_range(0, 1200)) - 800, 250)
                                          : 60'({$urandom, $urandom});
        sc_c = 3'($urandom_range(0, 7));
        oc_c = 3'($urandom_range(0, 7));
        al = ($urandom_range(0, 1) != 0) ? 9'($urandom_range(16, 160))
                                          : 9'($urandom_range(0, 511));
        hc = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
        fr = 1'($urandom);
        sk = 1'($urandom);
      end
    endcase
    put_reg(REG_SINGLE_THR, st);
    put_reg(REG_OFDM_THR, ot);
    put_reg(REG_SINGLE_CEIL, 60'(sc_c));
    put_reg(REG_OFDM_CEIL, 60'(oc_c));
    put_reg(REG_ALPHA, 60'(al));
    put_reg(REG_HOLD_COUNT, 60'(hc));
    put_reg(REG_FAST_RAMP, 60'(fr));
    put_reg(REG_STICKY_CLIMB, 60'(sk));
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  function automatic logic signed [11:0] clip12(int v);
    if (v > 2047) return 12'sh7ff;
    if (v < -2048) return 12'sh800;
    return 12'(v);
  endfunction

  // random event: mostly snr reports riding a slow channel walk, with ldpc
  // reports, failures, forced levels, unused commands and locks (when allowed) mixed in; unused fields carry noise
  function automatic mra_item_t random_event(bit lock_ok);
    mra_item_t it;
    int r;
    it.snr_sample = 12'($urandom);
    it.iteration_count = 8'($urandom);
    it.iteration_limit = 8'($urandom);
    it.level_request = 3'($urandom);
    chan = chan + int'($urandom_range(0, 60)) - 30;
    if ($urandom_range(0, 49) == 0) chan = int'($urandom_range(0, 2600)) - 1200;
    if (chan > 1400) chan = 1400;
    if (chan < -1200) chan = -1200;
    r = $urandom_range(0, 99);
    if (r < 28) it.command = CMD_SINGLE_SNR;
    else if (r < 56) it.command = CMD_OFDM_SNR;
    else if (r < 74) it.command = CMD_LDPC;
    else if (r < 82) it.command = CMD_FAILURE;
    else if (r < 87) it.command = CMD_FORCE_SNGL;
    else if (r < 92) it.command = CMD_FORCE_OFDM;
    else if (r < 96) it.command = CMD_NONE;
    else it.command = lock_ok ? CMD_LOCK_SNGL : CMD_OFDM_SNR;
    if ((it.command == CMD_SINGLE_SNR || it.command == CMD_OFDM_SNR) &&
        $urandom_range(0, 9) != 0)
      it.snr_sample = clip12(chan + int'($urandom_range(0, 64)) - 32);
    if (it.command == CMD_LDPC && $urandom_range(0, 4) != 0) begin
      it.iteration_count = 8'($urandom_range(1, 40));
      it.iteration_limit = 8'($urandom_range(20, 100));
    end
    return it;
  endfunction

  task automatic random_phase(bit lock_ok);
    chan = int'($urandom_range(0, 1500)) - 600;
    for (int i = 0; i < PHASE_ITEMS; i++) send_event(random_event(lock_ok), 1'b0, '0);
  endtask

  initial begin : stimulus
    // every input known from time zero
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = '0;
    in_snr_sample = '0;
    in_iteration_count = '0;
    in_iteration_limit = '0;
    in_level_request = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    selector_reset();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed rows under reset settings
    for (int i = 0; i < N_EARLY; i++) send_row(plan[i]);

    // random phases, each under a fresh register setting written while idle
    for (int ph = 0; ph < N_PHASES - 1; ph++) begin
      settle();
      program_setting(ph);
      random_phase(1'b0);
    end

    // lock rows, then a last phase with the single level locked
    for (int i = N_EARLY; i < N_EARLY + N_LATE; i++) send_row(plan[i]);
    settle();
    program_setting(N_PHASES - 1);
    random_phase(1'b1);

    // drain, then allow the pipeline latency for any stray result
    in_valid <= 1'b0;
    while (level_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (level_q.size() != 0) flag_error("results missing", level_q.size(), 0);

    $display("summary: %0d events sent, %0d results compared, %0d register settings",
             n_sent, n_checked, n_settings);
    $display("summary: %0d mismatches", n_errors);
    if (n_errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #(LIMIT_NS);
    $display("timeout with %0d results still owed", level_q.size());
    $display("tb_top: errors");
    $finish;
  end

endmodule
